>>> hw/rtl/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg
// Types and constants shared by the shortest path unit.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int VERT_W       = 4;
  localparam int MAX_VERTICES = 16;
  localparam int VCNT_W       = VERT_W + 1;
  localparam int WEIGHT_W     = 16;
  localparam int DIST_W       = 24;
  localparam int SUM_W        = DIST_W + 1;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(4);
  localparam logic [DIST_W-1:0] DIST_MAX     = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN     = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               op;
    logic [VERT_W-1:0]   tail;
    logic [VERT_W-1:0]   head;
    logic [WEIGHT_W-1:0] weight;
    logic [VERT_W-1:0]   src;
  } cmd_t;

  typedef struct packed {
    logic [VERT_W-1:0]   tail;
    logic [VERT_W-1:0]   head;
    logic [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_val;
    logic [VERT_W-1:0] pred;
  } dent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EREAD,
    ST_DREAD,
    ST_RELAX,
    ST_OREAD,
    ST_OWAIT
  } state_t;

endpackage

>>> hw/rtl/bfsp_in_if.sv
// ----------------------------------------------------------------------------
// bfsp_in_if
// Input item channel: edge, run and clear items.
// ----------------------------------------------------------------------------
interface bfsp_in_if import bfsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [VERT_W-1:0]   from_vertex;
  logic [VERT_W-1:0]   to_vertex;
  logic [WEIGHT_W-1:0] edge_weight;
  logic [VERT_W-1:0]   source_vertex;

  modport source (output valid, kind, from_vertex, to_vertex, edge_weight, source_vertex,
                  input ready);
  modport sink (input valid, kind, from_vertex, to_vertex, edge_weight, source_vertex,
                output ready);
endinterface

>>> hw/rtl/bfsp_out_if.sv
// ----------------------------------------------------------------------------
// bfsp_out_if
// Result item channel: one item per vertex after a run.
// ----------------------------------------------------------------------------
interface bfsp_out_if import bfsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VERT_W-1:0] vertex;
  logic [DIST_W-1:0] distance;
  logic              reachable;
  logic [VERT_W-1:0] predecessor;
  logic              has_predecessor;
  logic              last;

  modport source (output valid, vertex, distance, reachable, predecessor, has_predecessor,
                  last, input ready);
  modport sink (input valid, vertex, distance, reachable, predecessor, has_predecessor,
                last, output ready);
endinterface

>>> hw/rtl/bfsp_cfg_if.sv
// ----------------------------------------------------------------------------
// bfsp_cfg_if
// Configuration write channel for the vertex count register.
// ----------------------------------------------------------------------------
interface bfsp_cfg_if import bfsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VCNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/bfsp_front.sv
// ----------------------------------------------------------------------------
// bfsp_front
// Accepts input items, drops reserved kinds and registers commands.
// ----------------------------------------------------------------------------
module bfsp_front import bfsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bfsp_in_if.sink   in_ch,
  output logic      push_valid,
  input  logic      push_ready,
  output cmd_t      push_cmd
);

  logic hold_r, hold_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic accept, kind_ok;

  always_comb begin
    unique case (in_ch.kind) inside
      KIND_EDGE, KIND_RUN, KIND_CLEAR: kind_ok = 1'b1;
      default:                         kind_ok = 1'b0;
    endcase
  end

  assign in_ch.ready = !hold_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = hold_r;
  assign push_cmd    = cmd_r;

  always_comb begin
    hold_nxt = (hold_r && !push_ready) || (accept && kind_ok);
    cmd_nxt  = cmd_r;
    if (accept) begin
      cmd_nxt.op     = kind_t'(in_ch.kind);
      cmd_nxt.tail   = in_ch.from_vertex;
      cmd_nxt.head   = in_ch.to_vertex;
      cmd_nxt.weight = in_ch.edge_weight;
      cmd_nxt.src    = in_ch.source_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

>>> hw/rtl/bfsp_queue.sv
// ----------------------------------------------------------------------------
// bfsp_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module bfsp_queue import bfsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/bfsp_back.sv
// ----------------------------------------------------------------------------
// bfsp_back
// Edge store, relaxation sequencer and result output.
// ----------------------------------------------------------------------------
module bfsp_back import bfsp_pkg::*; #(
  parameter int MAX_EDGES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [VCNT_W-1:0] nv,
  input  logic              q_valid,
  output logic              q_ready,
  input  cmd_t              q_cmd,
  bfsp_out_if.source        out_ch
);

  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);

  edge_t edge_mem [MAX_EDGES];
  dent_t dist_mem [MAX_VERTICES];

  state_t                  state_r, state_nxt;
  logic [ECNT_W-1:0]       ecnt_r, ecnt_nxt;
  logic [EIDX_W-1:0]       e_r, e_nxt;
  logic [VCNT_W-1:0]       pass_r, pass_nxt;
  logic [VERT_W-1:0]       v_r, v_nxt;
  logic [MAX_VERTICES-1:0] reach_r, reach_nxt, hp_r, hp_nxt;

  edge_t             edge_rd_r;
  dent_t             rda_r, rdb_r;
  logic              ewe, dwe;
  logic [VERT_W-1:0] dwaddr, addr_b;
  dent_t             dwdata;

  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] cand;
  logic              edge_ok, upd, pass_end, run_end;

  always_comb begin
    sum = {rda_r.dist_val[DIST_W-1], rda_r.dist_val}
        + {{(SUM_W-WEIGHT_W){edge_rd_r.weight[WEIGHT_W-1]}}, edge_rd_r.weight};
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      cand = sum[SUM_W-1] ? DIST_MIN : DIST_MAX;
    end else begin
      cand = sum[DIST_W-1:0];
    end
    edge_ok = ({1'b0, edge_rd_r.tail} < nv) && ({1'b0, edge_rd_r.head} < nv)
           && reach_r[edge_rd_r.tail];
    upd = edge_ok && (!reach_r[edge_rd_r.head] ||
                      ($signed(cand) < $signed(rdb_r.dist_val)));
  end

  assign pass_end = (ECNT_W'(e_r) + ECNT_W'(1)) == ecnt_r;
  assign run_end  = (pass_r + VCNT_W'(1)) == nv;
  assign addr_b   = (state_r == ST_DREAD) ? edge_rd_r.head : v_r;

  always_comb begin
    state_nxt = state_r;
    ecnt_nxt  = ecnt_r;
    e_nxt     = e_r;
    pass_nxt  = pass_r;
    v_nxt     = v_r;
    reach_nxt = reach_r;
    hp_nxt    = hp_r;
    q_ready   = 1'b0;
    ewe       = 1'b0;
    dwe       = 1'b0;
    dwaddr    = edge_rd_r.head;
    dwdata    = '{dist_val: cand, pred: edge_rd_r.tail};
    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          unique case (q_cmd.op)
            KIND_EDGE: begin
              if (ecnt_r != ECNT_W'(MAX_EDGES)) begin
                ewe      = 1'b1;
                ecnt_nxt = ecnt_r + ECNT_W'(1);
              end
            end
            KIND_CLEAR: ecnt_nxt = '0;
            KIND_RUN: begin
              reach_nxt = '0;
              hp_nxt    = '0;
              if ({1'b0, q_cmd.src} < nv) begin
                reach_nxt[q_cmd.src] = 1'b1;
              end
              dwe      = 1'b1;
              dwaddr   = q_cmd.src;
              dwdata   = '0;
              e_nxt    = '0;
              pass_nxt = VCNT_W'(1);
              v_nxt    = '0;
              state_nxt = (nv > VCNT_W'(1) && ecnt_r != '0) ? ST_EREAD : ST_OREAD;
            end
            default: ;
          endcase
        end
      end
      ST_EREAD: state_nxt = ST_DREAD;
      ST_DREAD: state_nxt = ST_RELAX;
      ST_RELAX: begin
        if (upd) begin
          dwe                     = 1'b1;
          reach_nxt[edge_rd_r.head] = 1'b1;
          hp_nxt[edge_rd_r.head]    = 1'b1;
        end
        state_nxt = ST_EREAD;
        if (pass_end) begin
          e_nxt    = '0;
          pass_nxt = pass_r + VCNT_W'(1);
          if (run_end) begin
            state_nxt = ST_OREAD;
          end
        end else begin
          e_nxt = e_r + EIDX_W'(1);
        end
      end
      ST_OREAD: state_nxt = ST_OWAIT;
      ST_OWAIT: begin
        if (out_ch.ready) begin
          if (({1'b0, v_r} + VCNT_W'(1)) == nv) begin
            state_nxt = ST_IDLE;
          end else begin
            v_nxt     = v_r + VERT_W'(1);
            state_nxt = ST_OREAD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ecnt_r  <= '0;
      e_r     <= '0;
      pass_r  <= '0;
      v_r     <= '0;
      reach_r <= '0;
      hp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ecnt_r  <= ecnt_nxt;
      e_r     <= e_nxt;
      pass_r  <= pass_nxt;
      v_r     <= v_nxt;
      reach_r <= reach_nxt;
      hp_r    <= hp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ewe) begin
      edge_mem[ecnt_r[EIDX_W-1:0]] <= '{tail: q_cmd.tail, head: q_cmd.head,
                                         weight: q_cmd.weight};
    end
    edge_rd_r <= edge_mem[e_r];
  end

  always_ff @(posedge clk) begin
    if (dwe) begin
      dist_mem[dwaddr] <= dwdata;
    end
    rda_r <= dist_mem[edge_rd_r.tail];
    rdb_r <= dist_mem[addr_b];
  end

  logic reach_v, hp_v;
  assign reach_v                = reach_r[v_r];
  assign hp_v                   = reach_v && hp_r[v_r];
  assign out_ch.valid           = (state_r == ST_OWAIT);
  assign out_ch.vertex          = v_r;
  assign out_ch.distance        = reach_v ? rdb_r.dist_val : '0;
  assign out_ch.reachable       = reach_v;
  assign out_ch.predecessor     = hp_v ? rdb_r.pred : '0;
  assign out_ch.has_predecessor = hp_v;
  assign out_ch.last            = ({1'b0, v_r} + VCNT_W'(1)) == nv;

  a_ecnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= ECNT_W'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_ecnt_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> $stable(ecnt_r))
    else $error("edge count changed during a run");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OWAIT) |-> ({1'b0, v_r} < nv))
    else $error("result vertex beyond vertex count");

  a_relax_reach: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RELAX && upd) |=> reach_r[$past(edge_rd_r.head)])
    else $error("relaxed vertex not marked reachable");

endmodule

>>> hw/rtl/bellman_ford_shortest_paths_unit.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_unit
// Single-source shortest paths by repeated edge relaxation.
// Edge and clear items pass through the front register and the command queue
//   before the back end applies them. Run item: each edge step walks the states
//   EREAD, DREAD and RELAX through the edge store read port and the two distance
//   store read ports; result output can stall on out_ch.ready.
// Reset (sync, active low) empties the edge store and queue, clears reachable
//   flags and sets the vertex count to 4; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths_unit import bfsp_pkg::*; #(
  parameter int MAX_EDGES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  bfsp_in_if.sink    in_ch,
  bfsp_out_if.source out_ch,
  bfsp_cfg_if.sink   cfg_ch
);

  logic [VCNT_W-1:0] vcount_r, vcount_nxt, nv;
  logic              push_valid, push_ready, q_valid, q_ready;
  cmd_t              push_cmd, q_cmd;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    vcount_nxt = vcount_r;
    if (cfg_ch.valid) begin
      vcount_nxt = cfg_ch.data;
    end
    if (vcount_r == '0) begin
      nv = VCNT_W'(1);
    end else if (vcount_r > VCNT_W'(MAX_VERTICES)) begin
      nv = VCNT_W'(MAX_VERTICES);
    end else begin
      nv = vcount_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else begin
      vcount_r <= vcount_nxt;
    end
  end

  bfsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  bfsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  bfsp_back #(.MAX_EDGES(MAX_EDGES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .nv      (nv),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .out_ch  (out_ch)
  );

endmodule
